// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/cnlc_pkg.sv -----
// Shared types and constants of the card number checker.
`default_nettype none

package cnlc_pkg;

  localparam int BIN_W  = 64;          // binary card number width
  localparam int DIGITS = 20;          // decimal digits of a 64-bit value
  localparam int BCD_W  = 4 * DIGITS;
  localparam int CNT_W  = 6;

  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(BIN_W - 1);
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(DIGITS - 1);

  localparam logic [1:0] VERDICT_NONE  = 2'd0;
  localparam logic [1:0] VERDICT_LEAD4 = 2'd1;
  localparam logic [1:0] VERDICT_LEAD3 = 2'd2;
  localparam logic [1:0] VERDICT_LEAD5 = 2'd3;

  localparam logic [4:0] LEN_13 = 5'd13;
  localparam logic [4:0] LEN_15 = 5'd15;
  localparam logic [4:0] LEN_16 = 5'd16;

  typedef struct packed {
    logic start;     // load a new item, clear scan state
    logic conv;      // one shift-and-add-3 step
    logic scan;      // one digit of the Luhn / length pass
    logic load_out;  // capture the result into the output register
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic scan_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/card_number_luhn_classifier.sv -----
// Top level of the card number checker: Luhn mod-10 and prefix/length classification.
//
//  channel | ports                                   | role
//  --------+-----------------------------------------+---------------------------
//  in      | in_valid, in_ready, in_card_number      | 64-bit binary card number
//  out     | out_valid, out_ready, out_verdict,      | verdict, Luhn flag,
//          | out_checksum_ok, out_length_ok,         | length flag, digit count
//          | out_digit_total                         |
//
// Each item passes through a load, 64 shift-and-add-3 steps of the
// binary-to-BCD converter, 20 steps of the serial digit pass and a load into
// the output register. A new item is taken only after the previous one has
// been loaded into the output register.
// A new item is taken while a result waits.
// The result stalls in a hold state only when the output register is still
// full. Reset is synchronous, active low, and clears the sequencer and the
// step counter only.
`default_nettype none
`include "assert_macros.svh"

module card_number_luhn_classifier (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [63:0]  in_card_number,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_verdict,
  output logic        out_checksum_ok,
  output logic        out_length_ok,
  output logic [4:0]  out_digit_total
);
  import cnlc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cnlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cnlc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_card_number  (in_card_number),
    .out_verdict     (out_verdict),
    .out_checksum_ok (out_checksum_ok),
    .out_length_ok   (out_length_ok),
    .out_digit_total (out_digit_total)
  );

  // an accepted item keeps the block busy for the next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // a card type is only given for a valid length
  `ASSERT_ALWAYS(a_verdict_len, clk, rst_n, !out_valid || out_length_ok || out_verdict == VERDICT_NONE)
  // a card type is only given with a passing checksum
  `ASSERT_ALWAYS(a_verdict_sum, clk, rst_n, !out_valid || out_checksum_ok || out_verdict == VERDICT_NONE)

endmodule

`default_nettype wire

// ----- rtl/cnlc_ctrl.sv -----
// Sequencer of the card number checker: conversion, digit pass, result hand-off.
`default_nettype none

module cnlc_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  cnlc_pkg::sts_t   sts,
  output cnlc_pkg::cmd_t   cmd
);
  import cnlc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (sts.conv_last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        // wait until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cnlc_datapath.sv -----
// Datapath: double-dabble conversion, serial digit pass, classification, result register.
`default_nettype none

module cnlc_datapath (
  input  wire              clk,
  input  wire              rst_n,
  input  cnlc_pkg::cmd_t   cmd,
  output cnlc_pkg::sts_t   sts,
  input  wire [63:0]       in_card_number,
  output logic [1:0]       out_verdict,
  output logic             out_checksum_ok,
  output logic             out_length_ok,
  output logic [4:0]       out_digit_total
);
  import cnlc_pkg::*;

  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] bcd_adj;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       sum_r, sum_nxt;
  logic [4:0]       count_r, count_nxt;
  logic [3:0]       lead1_r, lead1_nxt;
  logic [6:0]       lead2_r, lead2_nxt;
  logic [3:0]       prev_r, prev_nxt;

  logic [3:0]       dig;
  logic [4:0]       dbl;
  logic [4:0]       contrib;
  logic [4:0]       acc;

  logic             len_ok, sum_ok;
  logic [1:0]       verdict;

  logic [1:0]       verdict_r;
  logic             sum_ok_r, len_ok_r;
  logic [4:0]       total_r;

  assign sts.conv_last = (cnt_r == CONV_LAST);
  assign sts.scan_last = (cnt_r == SCAN_LAST);

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      else bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
    end
  end

  // Luhn contribution of the digit at the bottom of the BCD word
  always_comb begin
    dig = bcd_r[3:0];
    dbl = {dig, 1'b0};
    if (cnt_r[0]) contrib = (dbl >= 5'd10) ? dbl - 5'd9 : dbl;
    else contrib = {1'b0, dig};
    acc = {1'b0, sum_r} + contrib;
  end

  always_comb begin
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    lead1_nxt = lead1_r;
    lead2_nxt = lead2_r;
    prev_nxt  = prev_r;
    if (cmd.start) begin
      bin_nxt   = in_card_number;
      bcd_nxt   = '0;
      cnt_nxt   = '0;
      sum_nxt   = '0;
      count_nxt = '0;
      lead1_nxt = '0;
      lead2_nxt = '0;
      prev_nxt  = '0;
    end else if (cmd.conv) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[BIN_W-1]};
      bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
      cnt_nxt = (cnt_r == CONV_LAST) ? '0 : cnt_r + 1'b1;
    end else if (cmd.scan) begin
      bcd_nxt = {4'd0, bcd_r[BCD_W-1:4]};
      cnt_nxt = cnt_r + 1'b1;
      sum_nxt = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
      // highest nonzero digit so far sets the count and the leading digits
      if (dig != 4'd0) begin
        count_nxt = cnt_r[4:0] + 5'd1;
        lead1_nxt = dig;
        lead2_nxt = {dig, 3'b000} + {2'b00, dig, 1'b0} + {3'b000, prev_r};
      end
      prev_nxt = dig;
    end
  end

  always_comb begin
    len_ok  = (count_r == LEN_13) || (count_r == LEN_15) || (count_r == LEN_16);
    sum_ok  = (sum_r == 4'd0);
    verdict = VERDICT_NONE;
    if (len_ok && sum_ok) begin
      if (lead1_r == 4'd4 && (count_r == LEN_13 || count_r == LEN_16))
        verdict = VERDICT_LEAD4;
      else if ((lead2_r == 7'd34 || lead2_r == 7'd37) && count_r == LEN_15)
        verdict = VERDICT_LEAD3;
      else if (((lead2_r >= 7'd51 && lead2_r <= 7'd55) || lead2_r == 7'd22)
               && count_r == LEN_16)
        verdict = VERDICT_LEAD5;
    end
  end

  always_ff @(posedge clk) begin
    bin_r   <= bin_nxt;
    bcd_r   <= bcd_nxt;
    sum_r   <= sum_nxt;
    count_r <= count_nxt;
    lead1_r <= lead1_nxt;
    lead2_r <= lead2_nxt;
    prev_r  <= prev_nxt;
    if (cmd.load_out) begin
      verdict_r <= verdict;
      sum_ok_r  <= sum_ok;
      len_ok_r  <= len_ok;
      total_r   <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  assign out_verdict     = verdict_r;
  assign out_checksum_ok = sum_ok_r;
  assign out_length_ok   = len_ok_r;
  assign out_digit_total = total_r;

endmodule

`default_nettype wire
